// File: rtl/pwm_switched_engine_sound_sequencer_unit_assert.svh
// Assertion macros used by the checker file of the engine sound sequencer.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the synchronous reset is asserted.
`ifndef PWM_SWITCHED_ENGINE_SOUND_SEQUENCER_UNIT_ASSERT_SVH
`define PWM_SWITCHED_ENGINE_SOUND_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PWMES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwmes assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PWMES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwmes assertion failed");

`endif

// File: rtl/pwmes_pkg.sv
// ----------------------------------------------------------------------------
// pwmes_pkg
// Types and constants of the PWM switched engine sound sequencer: payload
// structs, register indexes, engine modes and sound commands.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmes_pkg;

  localparam int PULSE_W    = 16;
  localparam int OFFSET_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PRESENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_PRESENT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PRESENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_OFFSET    = 3'd5;

  localparam logic [PULSE_W-1:0] THRESHOLD_RST = 16'd1500;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_PLAY_START   = 3'd1,
    CMD_LOOP_RUN     = 3'd2,
    CMD_PLAY_STOP    = 3'd3,
    CMD_STOP_CHANNEL = 3'd4
  } cmd_t;

  typedef struct packed {
    logic                reading_valid;
    logic [PULSE_W-1:0]  pulse_us;
    logic                channel_busy;
  } in_item_t;

  typedef struct packed {
    logic                switch_on;
    logic [1:0]          engine_mode;
    logic [2:0]          sound_command;
    logic [OFFSET_W-1:0] play_offset_ms;
  } out_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulse_threshold_us;
    logic                start_track_present;
    logic                run_track_present;
    logic                stop_track_present;
    logic [OFFSET_W-1:0] restart_offset_ms;
    logic [OFFSET_W-1:0] abort_offset_ms;
  } cfg_t;

  // One classified tick, handed from the front end to the sequencer
  typedef struct packed {
    logic level_on;
    logic channel_busy;
  } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/pwmes_front.sv
// ----------------------------------------------------------------------------
// pwmes_front
// Front end: accepts ticks, compares the pulse against the threshold with a
// level dependent deadzone and debounces the switch level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmes_front #(
  parameter int CONFIRM_READINGS = 3,
  parameter int DEADZONE         = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pwmes_pkg::in_item_t           in_data,
  input  wire logic [pwmes_pkg::PULSE_W-1:0] threshold,
  output logic                               q_push,
  output pwmes_pkg::q_entry_t                q_data,
  input  wire logic                          q_ready
);
  import pwmes_pkg::*;

  localparam logic [1:0]          CONFIRM = 2'(CONFIRM_READINGS);
  localparam logic [1:0]          CNT_MAX = 2'd3;
  localparam logic signed [17:0]  DZ      = 18'(DEADZONE);

  logic       level_on_r, level_on_nxt;
  logic [1:0] rise_r, rise_nxt;
  logic [1:0] fall_r, fall_nxt;
  logic [1:0] rise_inc, fall_inc;
  logic signed [17:0] pulse_s, thr_s, limit_s;
  logic       above;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Deadzone compare in a signed domain wide enough for threshold +/- DEADZONE
  always_comb begin
    pulse_s = signed'({2'b00, in_data.pulse_us});
    thr_s   = signed'({2'b00, threshold});
    limit_s = level_on_r ? (thr_s - DZ) : (thr_s + DZ);
    above   = (pulse_s >= limit_s);
  end

  assign rise_inc = (rise_r != CNT_MAX) ? rise_r + 2'd1 : rise_r;
  assign fall_inc = (fall_r != CNT_MAX) ? fall_r + 2'd1 : fall_r;

  // Debounce: a level change needs CONFIRM_READINGS disagreeing readings
  always_comb begin
    level_on_nxt = level_on_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    if (in_data.reading_valid) begin
      if (above && !level_on_r) begin
        fall_nxt = 2'd0;
        if (rise_inc >= CONFIRM) begin
          level_on_nxt = 1'b1;
          rise_nxt     = 2'd0;
        end else begin
          rise_nxt = rise_inc;
        end
      end else if (!above && level_on_r) begin
        rise_nxt = 2'd0;
        if (fall_inc >= CONFIRM) begin
          level_on_nxt = 1'b0;
          fall_nxt     = 2'd0;
        end else begin
          fall_nxt = fall_inc;
        end
      end else begin
        rise_nxt = 2'd0;
        fall_nxt = 2'd0;
      end
    end
  end

  assign q_data.level_on     = level_on_nxt;
  assign q_data.channel_busy = in_data.channel_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_on_r <= 1'b0;
      rise_r     <= 2'd0;
      fall_r     <= 2'd0;
    end else if (q_push) begin
      level_on_r <= level_on_nxt;
      rise_r     <= rise_nxt;
      fall_r     <= fall_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pwmes_queue.sv
// ----------------------------------------------------------------------------
// pwmes_queue
// Short FIFO between the front end and the sequencer so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmes_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pwmes_pkg::q_entry_t  push_data,
  output logic                      push_ready,
  output logic                      pop_valid,
  output pwmes_pkg::q_entry_t       pop_data,
  input  wire logic                 pop
);
  import pwmes_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pwmes_back.sv
// ----------------------------------------------------------------------------
// pwmes_back
// Back end: four-state engine sequencer that issues at most one sound command
// per tick, with a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmes_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pwmes_pkg::cfg_t      cfg,
  input  wire logic                 q_valid,
  input  wire pwmes_pkg::q_entry_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pwmes_pkg::out_item_t      out_data
);
  import pwmes_pkg::*;

  mode_t     mode_r, mode_nxt;
  logic      run_pending_r, run_pending_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  cmd_t      cmd;
  logic [OFFSET_W-1:0] offset;
  logic      active, level, busy;

  assign level  = q_data.level_on;
  assign busy   = q_data.channel_busy;
  assign active = (mode_r == MODE_STARTING) || (mode_r == MODE_RUNNING);
  assign q_pop  = q_valid && (!out_valid_r || out_ready);

  // Next state
  always_comb begin
    mode_nxt        = mode_r;
    run_pending_nxt = run_pending_r;
    if (mode_r == MODE_STOPPED && level) begin
      run_pending_nxt = cfg.run_track_present;
      mode_nxt = cfg.start_track_present ? MODE_STARTING : MODE_RUNNING;
    end else if (active && run_pending_r && !busy) begin
      mode_nxt        = MODE_RUNNING;
      run_pending_nxt = 1'b0;
    end else if (active && !level) begin
      mode_nxt = cfg.stop_track_present ? MODE_STOPPING : MODE_STOPPED;
    end else if (mode_r == MODE_STOPPING && level) begin
      run_pending_nxt = cfg.run_track_present;
      mode_nxt = cfg.start_track_present ? MODE_STARTING : MODE_RUNNING;
    end else if (mode_r == MODE_STOPPING && !busy) begin
      mode_nxt = MODE_STOPPED;
    end
  end

  // Command and offset for this tick
  always_comb begin
    cmd    = CMD_NONE;
    offset = '0;
    if (mode_r == MODE_STOPPED && level) begin
      if (cfg.start_track_present) begin
        cmd = CMD_PLAY_START;
      end
    end else if (active && run_pending_r && !busy) begin
      cmd = CMD_LOOP_RUN;
    end else if (active && !level) begin
      if (cfg.stop_track_present) begin
        cmd = CMD_PLAY_STOP;
        // aborting a start picks up the stop sound part way in
        if (mode_r == MODE_STARTING) begin
          offset = cfg.abort_offset_ms;
        end
      end else begin
        cmd = CMD_STOP_CHANNEL;
      end
    end else if (mode_r == MODE_STOPPING && level) begin
      if (cfg.start_track_present) begin
        cmd    = CMD_PLAY_START;
        offset = cfg.restart_offset_ms;
      end
    end
  end

  assign out_valid_nxt = q_pop | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_STOPPED;
      run_pending_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        mode_r        <= mode_nxt;
        run_pending_r <= run_pending_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.switch_on      <= level;
      out_data_r.engine_mode    <= mode_nxt;
      out_data_r.sound_command  <= cmd;
      out_data_r.play_offset_ms <= offset;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/pwm_switched_engine_sound_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pwm_switched_engine_sound_sequencer_unit
// PWM switch qualified engine sound sequencer: debounced switch level drives
// a stopped/starting/running/stopping sequencer that emits sound commands.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+---------------------------
//  in_     | input     | in_item_t   | in_valid / in_ready
//  out_    | output    | out_item_t  | out_valid / out_ready
//  cfg_    | input     | index, data | cfg_valid / cfg_ready (always 1)
//
//  One tick per cycle sustained while the result side is not stalled; a tick
//  enters the queue at its transfer edge, and the sequencer pops it and loads
//  the result register at a later edge, once the result side can take it.
//  Reset is synchronous, active low; registers return to their reset values.
//  The QUEUE_DEPTH deep queue lets the front end keep taking ticks while the
//  result side is stalled, until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_switched_engine_sound_sequencer_unit #(
  parameter int CONFIRM_READINGS = 3,
  parameter int DEADZONE         = 100,
  parameter int QUEUE_DEPTH      = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire pwmes_pkg::in_item_t              in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output pwmes_pkg::out_item_t                  out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pwmes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwmes_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwmes_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_ready, q_valid, q_pop;
  q_entry_t q_in, q_out;

  assign cfg_ready = 1'b1;

  // Register file writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PULSE_THRESHOLD: cfg_nxt.pulse_threshold_us  = cfg_data;
        REG_START_PRESENT:   cfg_nxt.start_track_present = cfg_data[0];
        REG_RUN_PRESENT:     cfg_nxt.run_track_present   = cfg_data[0];
        REG_STOP_PRESENT:    cfg_nxt.stop_track_present  = cfg_data[0];
        REG_RESTART_OFFSET:  cfg_nxt.restart_offset_ms   = cfg_data;
        REG_ABORT_OFFSET:    cfg_nxt.abort_offset_ms     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_threshold_us  <= THRESHOLD_RST;
      cfg_r.start_track_present <= 1'b0;
      cfg_r.run_track_present   <= 1'b0;
      cfg_r.stop_track_present  <= 1'b0;
      cfg_r.restart_offset_ms   <= '0;
      cfg_r.abort_offset_ms     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pwmes_front #(
    .CONFIRM_READINGS (CONFIRM_READINGS),
    .DEADZONE         (DEADZONE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .threshold (cfg_r.pulse_threshold_us),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_ready   (q_ready)
  );

  pwmes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_out),
    .pop        (q_pop)
  );

  pwmes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/pwmes_checker.sv
// ----------------------------------------------------------------------------
// pwmes_checker
// Port level checks of the engine sound sequencer: result hold under stall
// and consistency between sound command, engine mode and switch level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_switched_engine_sound_sequencer_unit_assert.svh"

module pwmes_checker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire pwmes_pkg::out_item_t  out_data
);
  import pwmes_pkg::*;

  // stalled result keeps its payload
  `PWMES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a nonzero offset only comes with a play command
  `PWMES_ASSERT_NOW(a_offset_cmd, clk, rst_n, out_valid && out_data.play_offset_ms != '0, out_data.sound_command == CMD_PLAY_START || out_data.sound_command == CMD_PLAY_STOP)

  // the loop sound always leaves the engine running
  `PWMES_ASSERT_NOW(a_loop_mode, clk, rst_n, out_valid && out_data.sound_command == CMD_LOOP_RUN, out_data.engine_mode == MODE_RUNNING)

  // a start sound needs the switch on and enters starting
  `PWMES_ASSERT_NOW(a_start_mode, clk, rst_n, out_valid && out_data.sound_command == CMD_PLAY_START, out_data.switch_on && out_data.engine_mode == MODE_STARTING)

  // a hard channel stop only happens with the switch off, into stopped
  `PWMES_ASSERT_NOW(a_stop_mode, clk, rst_n, out_valid && out_data.sound_command == CMD_STOP_CHANNEL, !out_data.switch_on && out_data.engine_mode == MODE_STOPPED)

endmodule

bind pwm_switched_engine_sound_sequencer_unit pwmes_checker u_pwmes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
